FILE: rtl/sad_pkg.sv
package sad_pkg;

  localparam int ID_W       = 8;
  localparam int VAL_W      = 8;
  localparam int RAW_W      = 48;
  localparam int PRETTY_W   = 64;
  localparam int UNIT_W     = 3;
  localparam int QUIRK_W    = 22;
  localparam int MAXSEC_W   = 48;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_QUIRK_FLAGS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SECTORS = 8'd1;

  // quirk bit positions
  localparam int QB_9MIN     = 0;
  localparam int QB_9SEC     = 1;
  localparam int QB_9HALF    = 2;
  localparam int QB_192      = 3;
  localparam int QB_194X10   = 5;
  localparam int QB_194UNK   = 6;
  localparam int QB_200      = 7;
  localparam int QB_201      = 8;
  localparam int QB_5UNK     = 9;
  localparam int QB_9UNK     = 10;
  localparam int QB_197UNK   = 11;
  localparam int QB_198UNK   = 12;
  localparam int QB_190UNK   = 13;
  localparam int QB_232      = 14;
  localparam int QB_233      = 15;
  localparam int QB_225      = 16;
  localparam int QB_4UNUSED  = 17;
  localparam int QB_226      = 18;
  localparam int QB_227      = 19;
  localparam int QB_228      = 20;
  localparam int QB_3UNUSED  = 21;

  // normalized value limits
  localparam logic [VAL_W-1:0] VAL_MAX     = 8'hFD;
  localparam logic [VAL_W-1:0] THR_INVALID = 8'hFE;

  // scaling constants
  localparam logic [21:0] HOURS_MS  = 22'd3600000;
  localparam logic [9:0]  MK_SCALE  = 10'd1000;
  localparam logic [18:0] MK_OFFSET = 19'd273150;
  localparam logic [15:0] MIN_MS    = 16'd60000;

  // megabyte path: (raw * 2^25 mod 2^64) / 10^6 == floor(r * 2^19 / 15625), r = raw[38:0]
  localparam int          MB_R_W         = 39;
  localparam int          MB_SPLIT       = 20;
  localparam logic [13:0] MB_DIV         = 14'd15625;
  localparam int          MB_REM_W       = 14;
  localparam int          MB_FRAC_W      = 19;
  localparam int          Q_W            = 26;
  localparam logic [40:0] RECIP_Q        = 41'd1152921504607;  // ceil(2^54 / 15625)
  localparam int          RECIP_Q_SHIFT  = 54;
  localparam logic [33:0] RECIP_F        = 34'd9007199255;     // ceil(2^47 / 15625)
  localparam int          RECIP_F_SHIFT  = 28;

  // plausibility limits
  localparam logic [PRETTY_W-1:0] MS_SHORT_MAX = 64'd3600000;
  localparam logic [PRETTY_W-1:0] MS_LONG_MAX  = 64'd946080000000;
  localparam logic [PRETTY_W-1:0] MK_MIN       = 64'd258150;
  localparam logic [PRETTY_W-1:0] MK_MAX       = 64'd373150;
  localparam logic [PRETTY_W-1:0] SECT_ALL32   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [PRETTY_W-1:0] SECT_ALL48   = 64'h0000_FFFF_FFFF_FFFF;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_UNKNOWN = 3'd0,
    UNIT_NONE    = 3'd1,
    UNIT_MS      = 3'd2,
    UNIT_SECTORS = 3'd3,
    UNIT_MK      = 3'd4,
    UNIT_SPCT    = 3'd5,
    UNIT_PCT     = 3'd6,
    UNIT_MB      = 3'd7
  } unit_t;

  typedef enum logic [2:0] {
    SC_RAW,
    SC_RAW16,
    SC_RAW32,
    SC_HOURS,
    SC_CUR,
    SC_MK,
    SC_MIN,
    SC_MB
  } scale_t;

  typedef enum logic [2:0] {
    CHK_NONE,
    CHK_MS_SHORT,
    CHK_SECT,
    CHK_SECT_WARN,
    CHK_MS_LONG,
    CHK_MK
  } chk_t;

  typedef struct packed {
    logic current_ok;
    logic worst_ok;
    logic threshold_ok;
    logic good_now;
    logic good_now_known;
    logic good_past;
    logic good_past_known;
    logic warn;
  } flags_t;

  typedef struct packed {
    unit_t  unit;
    scale_t sel;
    chk_t   chk;
    flags_t flags;
  } ctx_t;

  function automatic unit_t unit_table(input logic [ID_W-1:0] id);
    unit_t u;
    u = UNIT_UNKNOWN;
    case (id) inside
      8'd1, 8'd4, 8'd7, [8'd10:8'd13], 8'd171, 8'd172, [8'd175:8'd184],
      8'd188, 8'd189, 8'd191, 8'd192, 8'd193, 8'd195, 8'd196, [8'd199:8'd202],
      8'd204, 8'd205, 8'd221, 8'd223, 8'd225, 8'd227, 8'd228, 8'd250: u = UNIT_NONE;
      8'd3, 8'd9, 8'd222, 8'd226, 8'd240:                          u = UNIT_MS;
      8'd5, 8'd187, 8'd197, 8'd198, 8'd234:                        u = UNIT_SECTORS;
      8'd190, 8'd194, 8'd231:                                      u = UNIT_MK;
      8'd170, 8'd232:                                              u = UNIT_PCT;
      8'd241, 8'd242:                                              u = UNIT_MB;
      default:                                                     u = UNIT_UNKNOWN;
    endcase
    return u;
  endfunction

  function automatic unit_t pick_unit(input logic [ID_W-1:0] id,
                                      input logic [QUIRK_W-1:0] q);
    unit_t u;
    u = unit_table(id);
    case (id)
      8'd3:   if (q[QB_3UNUSED]) u = UNIT_UNKNOWN;
      8'd4:   if (q[QB_4UNUSED]) u = UNIT_UNKNOWN;
      8'd5:   if (q[QB_5UNK]) u = UNIT_UNKNOWN;
      8'd9: begin
        if (q[QB_9MIN] || q[QB_9SEC] || q[QB_9HALF]) u = UNIT_MS;
        else if (q[QB_9UNK]) u = UNIT_UNKNOWN;
      end
      8'd190: if (q[QB_190UNK]) u = UNIT_UNKNOWN;
      8'd192: if (q[QB_192]) u = UNIT_NONE;
      8'd194: begin
        if (q[QB_194X10]) u = UNIT_MK;
        else if (q[QB_194UNK]) u = UNIT_UNKNOWN;
      end
      8'd197: if (q[QB_197UNK]) u = UNIT_UNKNOWN;
      8'd198: if (q[QB_198UNK]) u = UNIT_UNKNOWN;
      8'd200: if (q[QB_200]) u = UNIT_NONE;
      8'd201: if (q[QB_201]) u = UNIT_NONE;
      8'd225: if (q[QB_225]) u = UNIT_MB;
      8'd226: if (q[QB_226]) u = UNIT_SPCT;
      8'd227: if (q[QB_227]) u = UNIT_SPCT;
      8'd228: if (q[QB_228]) u = UNIT_MS;
      8'd232: if (q[QB_232]) u = UNIT_PCT;
      8'd233: if (q[QB_233]) u = UNIT_PCT;
      default: ;
    endcase
    return u;
  endfunction

  function automatic scale_t scale_sel(input logic [ID_W-1:0] id);
    scale_t s;
    case (id) inside
      8'd3:                    s = SC_RAW16;
      8'd5, 8'd197:            s = SC_RAW32;
      8'd9, 8'd222, 8'd240:    s = SC_HOURS;
      8'd170, 8'd232:          s = SC_CUR;
      8'd190, 8'd194, 8'd231:  s = SC_MK;
      8'd228:                  s = SC_MIN;
      8'd241, 8'd242:          s = SC_MB;
      default:                 s = SC_RAW;
    endcase
    return s;
  endfunction

  function automatic chk_t chk_sel(input logic [ID_W-1:0] id);
    chk_t c;
    case (id) inside
      8'd3, 8'd226:            c = CHK_MS_SHORT;
      8'd5, 8'd197:            c = CHK_SECT_WARN;
      8'd187, 8'd198:          c = CHK_SECT;
      8'd9, 8'd222, 8'd240:    c = CHK_MS_LONG;
      8'd190, 8'd194, 8'd231:  c = CHK_MK;
      default:                 c = CHK_NONE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/sad_in_if.sv
interface sad_in_if;
  logic                          valid;
  logic                          ready;
  logic [sad_pkg::ID_W-1:0]      attr_id;
  logic [sad_pkg::VAL_W-1:0]     current_value;
  logic [sad_pkg::VAL_W-1:0]     worst_value;
  logic [sad_pkg::VAL_W-1:0]     threshold;
  logic [sad_pkg::RAW_W-1:0]     raw_value;

  modport source (
    output valid, attr_id, current_value, worst_value, threshold, raw_value,
    input  ready
  );
  modport sink (
    input  valid, attr_id, current_value, worst_value, threshold, raw_value,
    output ready
  );
endinterface

FILE: rtl/sad_out_if.sv
interface sad_out_if;
  logic                          valid;
  logic                          ready;
  logic [sad_pkg::PRETTY_W-1:0]  pretty_value;
  logic [sad_pkg::UNIT_W-1:0]    unit_code;
  logic                          current_ok;
  logic                          worst_ok;
  logic                          threshold_ok;
  logic                          good_now;
  logic                          good_now_known;
  logic                          good_past;
  logic                          good_past_known;
  logic                          warn;

  modport source (
    output valid, pretty_value, unit_code, current_ok, worst_ok, threshold_ok,
           good_now, good_now_known, good_past, good_past_known, warn,
    input  ready
  );
  modport sink (
    input  valid, pretty_value, unit_code, current_ok, worst_ok, threshold_ok,
           good_now, good_now_known, good_past, good_past_known, warn,
    output ready
  );
endinterface

FILE: rtl/sad_cfg_if.sv
interface sad_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sad_pkg::CFG_IDX_W-1:0]   index;
  logic [sad_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/sad_front.sv
module sad_front (
  input  logic [sad_pkg::ID_W-1:0]    attr_id,
  input  logic [sad_pkg::VAL_W-1:0]   current_value,
  input  logic [sad_pkg::VAL_W-1:0]   worst_value,
  input  logic [sad_pkg::VAL_W-1:0]   threshold,
  input  logic [sad_pkg::QUIRK_W-1:0] quirk_flags,
  output sad_pkg::ctx_t               ctx
);

  logic thr_judged;

  always_comb begin
    ctx.unit = sad_pkg::pick_unit(attr_id, quirk_flags);
    ctx.sel  = sad_pkg::scale_sel(attr_id);
    ctx.chk  = sad_pkg::chk_sel(attr_id);

    ctx.flags.current_ok   = (current_value != '0) && (current_value <= sad_pkg::VAL_MAX);
    ctx.flags.worst_ok     = (worst_value != '0) && (worst_value <= sad_pkg::VAL_MAX);
    ctx.flags.threshold_ok = (threshold != sad_pkg::THR_INVALID);

    thr_judged = (threshold != '0) && (threshold <= sad_pkg::VAL_MAX);

    ctx.flags.good_now_known  = thr_judged && ctx.flags.current_ok;
    ctx.flags.good_now        = ctx.flags.good_now_known ? (current_value > threshold) : 1'b1;
    ctx.flags.good_past_known = thr_judged && ctx.flags.worst_ok;
    ctx.flags.good_past       = ctx.flags.good_past_known ? (worst_value > threshold) : 1'b1;

    // sector warn gets added later, once the pretty value is checked
    ctx.flags.warn = (ctx.flags.good_now_known && !ctx.flags.good_now) ||
                     (ctx.flags.good_past_known && !ctx.flags.good_past);
  end

endmodule

FILE: rtl/smart_attribute_decoder.sv
// SMART attribute decoder.
//
// Channels: in_ch takes one attribute (id, current, worst, threshold, raw);
// out_ch returns one decoded result per attribute in the same order;
// cfg_ch writes the quirk flags (index 0) and the sector limit (index 1).
// All three use valid/ready; a request moves when both are high.
// cfg_ch is always ready. Write configuration only while the block is idle.
//
// Six register stages: front decode, constant multiplies, product sum and
// value select, range checks with remainder, fraction multiply, output.
// A result is valid once its request has passed every stage in order; one
// attribute can be accepted every clock while out_ch does not stall.
//
// Reset clears every stage valid bit and both configuration registers.
// When out_ch stalls, the output register holds its result and the stages
// behind it keep filling empty slots; in_ch.ready drops once all six stages
// hold an item.
module smart_attribute_decoder (
  input  logic       clk,
  input  logic       rst_n,
  sad_in_if.sink     in_ch,
  sad_out_if.source  out_ch,
  sad_cfg_if.sink    cfg_ch
);

  // configuration
  logic [sad_pkg::QUIRK_W-1:0]  quirk_flags_r;
  logic [sad_pkg::MAXSEC_W-1:0] max_sectors_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quirk_flags_r <= '0;
      max_sectors_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == sad_pkg::REG_QUIRK_FLAGS) begin
        quirk_flags_r <= cfg_ch.data[sad_pkg::QUIRK_W-1:0];
      end else if (cfg_ch.index == sad_pkg::REG_MAX_SECTORS) begin
        max_sectors_r <= cfg_ch.data[sad_pkg::MAXSEC_W-1:0];
      end
    end
  end

  // stage enables: a stage loads when it is empty or its content moves on
  logic en1, en2, en3, en4, en5, en6;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  assign en6 = !v6_r || out_ch.ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 1: unit, scale and check selection, validity flags
  sad_pkg::ctx_t               ctx1_nxt, ctx1_r;
  logic [sad_pkg::VAL_W-1:0]   cur1_r;
  logic [sad_pkg::RAW_W-1:0]   raw1_r;

  sad_front u_front (
    .attr_id       (in_ch.attr_id),
    .current_value (in_ch.current_value),
    .worst_value   (in_ch.worst_value),
    .threshold     (in_ch.threshold),
    .quirk_flags   (quirk_flags_r),
    .ctx           (ctx1_nxt)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      ctx1_r <= ctx1_nxt;
      cur1_r <= in_ch.current_value;
      raw1_r <= in_ch.raw_value;
    end
  end

  // stage 2: constant multiplies
  sad_pkg::ctx_t               ctx2_r;
  logic [sad_pkg::VAL_W-1:0]   cur2_r;
  logic [sad_pkg::RAW_W-1:0]   raw2_r;
  logic [53:0]                 ms2_nxt, ms2_r;
  logic [25:0]                 mk2_nxt, mk2_r;
  logic [63:0]                 min2_nxt, min2_r;
  logic [60:0]                 pp0_nxt, pp0_r;
  logic [59:0]                 pp1_nxt, pp1_r;

  always_comb begin
    ms2_nxt  = 54'(raw1_r[31:0]) * 54'(sad_pkg::HOURS_MS);
    mk2_nxt  = 26'(raw1_r[15:0]) * 26'(sad_pkg::MK_SCALE) + 26'(sad_pkg::MK_OFFSET);
    min2_nxt = 64'(raw1_r) * 64'(sad_pkg::MIN_MS);
    // reciprocal of 15625, split over the low and high parts of r
    pp0_nxt  = 61'(raw1_r[sad_pkg::MB_SPLIT-1:0]) * 61'(sad_pkg::RECIP_Q);
    pp1_nxt  = 60'(raw1_r[sad_pkg::MB_R_W-1:sad_pkg::MB_SPLIT]) * 60'(sad_pkg::RECIP_Q);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ctx2_r <= ctx1_r;
      cur2_r <= cur1_r;
      raw2_r <= raw1_r;
      ms2_r  <= ms2_nxt;
      mk2_r  <= mk2_nxt;
      min2_r <= min2_nxt;
      pp0_r  <= pp0_nxt;
      pp1_r  <= pp1_nxt;
    end
  end

  // stage 3: pick the scaled value, finish the quotient r / 15625
  sad_pkg::ctx_t                  ctx3_r;
  logic [sad_pkg::PRETTY_W-1:0]   p3_nxt, p3_r;
  logic [79:0]                    qsum;
  logic [sad_pkg::Q_W-1:0]        q3_nxt, q3_r;
  logic [sad_pkg::MB_R_W-1:0]     r3_r;

  always_comb begin
    case (ctx2_r.sel)
      sad_pkg::SC_RAW16: p3_nxt = 64'(raw2_r[15:0]);
      sad_pkg::SC_RAW32: p3_nxt = 64'(raw2_r[31:0]);
      sad_pkg::SC_HOURS: p3_nxt = 64'(ms2_r);
      sad_pkg::SC_CUR:   p3_nxt = 64'(cur2_r);
      sad_pkg::SC_MK:    p3_nxt = 64'(mk2_r);
      sad_pkg::SC_MIN:   p3_nxt = min2_r;
      sad_pkg::SC_MB:    p3_nxt = '0;
      default:           p3_nxt = 64'(raw2_r);
    endcase
    qsum   = 80'(pp0_r) + {pp1_r, 20'b0};
    q3_nxt = qsum[sad_pkg::RECIP_Q_SHIFT +: sad_pkg::Q_W];
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      ctx3_r <= ctx2_r;
      p3_r   <= p3_nxt;
      q3_r   <= q3_nxt;
      r3_r   <= raw2_r[sad_pkg::MB_R_W-1:0];
    end
  end

  // stage 4: plausibility checks, remainder of r / 15625
  sad_pkg::ctx_t                  ctx4_nxt, ctx4_r;
  logic [sad_pkg::PRETTY_W-1:0]   p4_r;
  logic [sad_pkg::Q_W-1:0]        q4_r;
  logic [sad_pkg::MB_R_W-1:0]     rem_full;
  logic [sad_pkg::MB_REM_W-1:0]   m4_r;
  logic                           implausible;
  logic                           sect_warn;

  always_comb begin
    implausible = 1'b0;
    sect_warn   = 1'b0;
    case (ctx3_r.chk)
      sad_pkg::CHK_MS_SHORT: begin
        implausible = (ctx3_r.unit == sad_pkg::UNIT_MS) &&
                      ((p3_r == '0) || (p3_r > sad_pkg::MS_SHORT_MAX));
      end
      sad_pkg::CHK_MS_LONG: begin
        implausible = (ctx3_r.unit == sad_pkg::UNIT_MS) &&
                      ((p3_r == '0) || (p3_r > sad_pkg::MS_LONG_MAX));
      end
      sad_pkg::CHK_MK: begin
        implausible = (ctx3_r.unit == sad_pkg::UNIT_MK) &&
                      ((p3_r < sad_pkg::MK_MIN) || (p3_r > sad_pkg::MK_MAX));
      end
      sad_pkg::CHK_SECT, sad_pkg::CHK_SECT_WARN: begin
        if (ctx3_r.unit == sad_pkg::UNIT_SECTORS) begin
          implausible = (p3_r == sad_pkg::SECT_ALL32) || (p3_r == sad_pkg::SECT_ALL48) ||
                        ((max_sectors_r != '0) && (p3_r > 64'(max_sectors_r)));
          // reallocated and pending counts warn when nonzero
          sect_warn = !implausible && (ctx3_r.chk == sad_pkg::CHK_SECT_WARN) &&
                      (p3_r != '0);
        end
      end
      default: ;
    endcase

    ctx4_nxt = ctx3_r;
    if (implausible) ctx4_nxt.unit = sad_pkg::UNIT_UNKNOWN;
    ctx4_nxt.flags.warn = ctx3_r.flags.warn || sect_warn;

    rem_full = r3_r - 39'(40'(q3_r) * 40'(sad_pkg::MB_DIV));
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ctx4_r <= ctx4_nxt;
      p4_r   <= p3_r;
      q4_r   <= q3_r;
      m4_r   <= rem_full[sad_pkg::MB_REM_W-1:0];
    end
  end

  // stage 5: fraction floor(m * 2^19 / 15625)
  sad_pkg::ctx_t                  ctx5_r;
  logic [sad_pkg::PRETTY_W-1:0]   p5_r;
  logic [sad_pkg::Q_W-1:0]        q5_r;
  logic [47:0]                    fprod;
  logic [sad_pkg::MB_FRAC_W-1:0]  f5_nxt, f5_r;

  always_comb begin
    fprod  = 48'(m4_r) * 48'(sad_pkg::RECIP_F);
    f5_nxt = fprod[sad_pkg::RECIP_F_SHIFT +: sad_pkg::MB_FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      ctx5_r <= ctx4_r;
      p5_r   <= p4_r;
      q5_r   <= q4_r;
      f5_r   <= f5_nxt;
    end
  end

  // stage 6: output register
  logic [sad_pkg::PRETTY_W-1:0]   pretty6_nxt, pretty6_r;
  sad_pkg::unit_t                 unit6_r;
  sad_pkg::flags_t                flags6_r;

  always_comb begin
    if (ctx5_r.unit == sad_pkg::UNIT_UNKNOWN) begin
      pretty6_nxt = '0;
    end else if (ctx5_r.sel == sad_pkg::SC_MB) begin
      pretty6_nxt = 64'({q5_r, f5_r});
    end else begin
      pretty6_nxt = p5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      pretty6_r <= pretty6_nxt;
      unit6_r   <= ctx5_r.unit;
      flags6_r  <= ctx5_r.flags;
    end
  end

  assign out_ch.valid           = v6_r;
  assign out_ch.pretty_value    = pretty6_r;
  assign out_ch.unit_code       = unit6_r;
  assign out_ch.current_ok      = flags6_r.current_ok;
  assign out_ch.worst_ok        = flags6_r.worst_ok;
  assign out_ch.threshold_ok    = flags6_r.threshold_ok;
  assign out_ch.good_now        = flags6_r.good_now;
  assign out_ch.good_now_known  = flags6_r.good_now_known;
  assign out_ch.good_past       = flags6_r.good_past;
  assign out_ch.good_past_known = flags6_r.good_past_known;
  assign out_ch.warn            = flags6_r.warn;

  // an unknown unit never carries a value
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.unit_code == sad_pkg::UNIT_UNKNOWN)) |->
      (out_ch.pretty_value == '0))
    else $error("pretty value nonzero with unknown unit");

  // a judged state needs valid inputs on both sides
  a_judged_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.good_now_known) |->
      (out_ch.current_ok && out_ch.threshold_ok))
    else $error("good_now judged without valid current or threshold");

  // an empty output stage means nothing can block the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while output stage is empty");

  // a failed judgement always raises warn
  a_warn_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ((out_ch.good_now_known && !out_ch.good_now) ||
                      (out_ch.good_past_known && !out_ch.good_past))) |->
      out_ch.warn)
    else $error("threshold failure without warn");

endmodule
